>>> rtl/core/tbud_pkg.sv
package tbud_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_CROSS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_CROSS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MAKEUP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MID_MAKEUP  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MAKEUP = 3'd7;

    localparam logic [15:0] LOW_CROSS_RESET  = 16'd1928;
    localparam logic [15:0] HIGH_CROSS_RESET = 16'd34242;
    localparam logic [16:0] DEPTH_RESET      = 17'd65536;
    localparam logic [15:0] ATTACK_RESET     = 16'd64170;
    localparam logic [15:0] RELEASE_RESET    = 16'd65372;

    localparam logic [15:0] CROSS_MAX = 16'd64880;
    localparam logic [16:0] DEPTH_ONE = 17'd65536;
    localparam logic [31:0] ENV_FLOOR = 32'd21475;
    localparam logic signed [19:0] DB_PER_LOG2 = 20'sd394566;
    localparam logic signed [19:0] LOG2_PER_DB = 20'sd10885;
    localparam logic [15:0] UP_CAP = 16'd4608;

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    localparam logic [1:0] SM_LP_L = 2'd0;
    localparam logic [1:0] SM_LP_R = 2'd1;
    localparam logic [1:0] SM_HP_L = 2'd2;
    localparam logic [1:0] SM_HP_R = 2'd3;

    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_SM_MUL   = 4'd2;
    localparam logic [3:0] OP_SM_ADD   = 4'd3;
    localparam logic [3:0] OP_BAND     = 4'd4;
    localparam logic [3:0] OP_ENV_MUL  = 4'd5;
    localparam logic [3:0] OP_ENV_UPD  = 4'd6;
    localparam logic [3:0] OP_LOG      = 4'd7;
    localparam logic [3:0] OP_DB_MUL   = 4'd8;
    localparam logic [3:0] OP_GAIN_MUL = 4'd9;
    localparam logic [3:0] OP_T_MUL    = 4'd10;
    localparam logic [3:0] OP_WET_MUL  = 4'd11;
    localparam logic [3:0] OP_WET_SH   = 4'd12;
    localparam logic [3:0] OP_MIX_MUL  = 4'd13;
    localparam logic [3:0] OP_MIX_ACC  = 4'd14;
    localparam logic [3:0] OP_OUT      = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;
        logic [1:0] band;
        logic       ch;
    } cmd_t;

    function automatic logic signed [15:0] thr_db(input logic [1:0] b);
        case (b)
            BAND_LOW:  return -16'sd5120;
            BAND_MID:  return -16'sd4608;
            default:   return -16'sd3840;
        endcase
    endfunction

    function automatic logic [16:0] down_slope(input logic [1:0] b);
        case (b)
            BAND_LOW:  return 17'd54613;
            BAND_MID:  return 17'd57344;
            default:   return 17'd58982;
        endcase
    endfunction

    function automatic logic [16:0] up_slope(input logic [1:0] b);
        case (b)
            BAND_LOW:  return 17'd46811;
            BAND_MID:  return 17'd49152;
            default:   return 17'd50972;
        endcase
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        for (int s = 31; s >= 0; s--)
        begin
            b = 64'd1 << (2 * s);
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // log2(1 + i/2^t) in q.16 by repeated squaring
    function automatic logic [15:0] log_entry(input int t, input int i);
        logic [63:0] y;
        logic [15:0] r;
        y = (64'(1 << t) + 64'(i)) << (30 - t);
        r = 16'd0;
        for (int b = 15; b >= 0; b--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    // exp2 mantissa in q1.16
    function automatic logic [16:0] exp_mant(input int t, input int i);
        logic [63:0] v;
        logic [63:0] acc;
        v = 64'd2 << 30;
        acc = 64'd1 << 30;
        for (int j = 1; j <= t; j++)
        begin
            v = isqrt64(v << 30);
            if (((i >> (t - j)) & 1) != 0)
            begin
                acc = (acc * v) >> 30;
            end
        end
        return 17'(acc >> 14);
    endfunction

endpackage

>>> rtl/core/tbud_if.sv
interface tbud_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface tbud_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

>>> rtl/core/tbud_ctrl.sv
module tbud_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output tbud_pkg::cmd_t   cmd
);

    localparam logic [3:0] S_IDLE     = tbud_pkg::OP_NOP;
    localparam logic [3:0] S_SM_MUL   = tbud_pkg::OP_SM_MUL;
    localparam logic [3:0] S_SM_ADD   = tbud_pkg::OP_SM_ADD;
    localparam logic [3:0] S_BAND     = tbud_pkg::OP_BAND;
    localparam logic [3:0] S_ENV_MUL  = tbud_pkg::OP_ENV_MUL;
    localparam logic [3:0] S_ENV_UPD  = tbud_pkg::OP_ENV_UPD;
    localparam logic [3:0] S_LOG      = tbud_pkg::OP_LOG;
    localparam logic [3:0] S_DB_MUL   = tbud_pkg::OP_DB_MUL;
    localparam logic [3:0] S_GAIN_MUL = tbud_pkg::OP_GAIN_MUL;
    localparam logic [3:0] S_T_MUL    = tbud_pkg::OP_T_MUL;
    localparam logic [3:0] S_WET_MUL  = tbud_pkg::OP_WET_MUL;
    localparam logic [3:0] S_WET_SH   = tbud_pkg::OP_WET_SH;
    localparam logic [3:0] S_MIX_MUL  = tbud_pkg::OP_MIX_MUL;
    localparam logic [3:0] S_MIX_ACC  = tbud_pkg::OP_MIX_ACC;
    localparam logic [3:0] S_OUT      = tbud_pkg::OP_OUT;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] sm_reg;
    logic [1:0] sm_next;
    logic [1:0] band_reg;
    logic [1:0] band_next;
    logic       ch_reg;
    logic       ch_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        sm_next = sm_reg;
        band_next = band_reg;
        ch_next = ch_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op = state_reg;
        cmd.sel = sm_reg;
        cmd.band = band_reg;
        cmd.ch = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.op = tbud_pkg::OP_NOP;
                if (in_valid)
                begin
                    cmd.op = tbud_pkg::OP_LOAD;
                    sm_next = tbud_pkg::SM_LP_L;
                    state_next = S_SM_MUL;
                end
            end
            S_SM_MUL:   state_next = S_SM_ADD;
            S_SM_ADD:
            begin
                if (sm_reg == tbud_pkg::SM_HP_R)
                begin
                    band_next = tbud_pkg::BAND_LOW;
                    ch_next = 1'b0;
                    state_next = S_BAND;
                end
                else
                begin
                    sm_next = sm_reg + 2'd1;
                    state_next = S_SM_MUL;
                end
            end
            S_BAND:     state_next = S_ENV_MUL;
            S_ENV_MUL:  state_next = S_ENV_UPD;
            S_ENV_UPD:  state_next = S_LOG;
            S_LOG:      state_next = S_DB_MUL;
            S_DB_MUL:   state_next = S_GAIN_MUL;
            S_GAIN_MUL: state_next = S_T_MUL;
            S_T_MUL:    state_next = S_WET_MUL;
            S_WET_MUL:  state_next = S_WET_SH;
            S_WET_SH:   state_next = S_MIX_MUL;
            S_MIX_MUL:  state_next = S_MIX_ACC;
            S_MIX_ACC:
            begin
                if (ch_reg && band_reg == tbud_pkg::BAND_HIGH)
                begin
                    state_next = S_OUT;
                end
                else if (ch_reg)
                begin
                    ch_next = 1'b0;
                    band_next = band_reg + 2'd1;
                    state_next = S_BAND;
                end
                else
                begin
                    ch_next = 1'b1;
                    state_next = S_BAND;
                end
            end
            S_OUT:
            begin
                cmd.op = tbud_pkg::OP_NOP;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = tbud_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                cmd.op = tbud_pkg::OP_NOP;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sm_reg <= tbud_pkg::SM_LP_L;
            band_reg <= tbud_pkg::BAND_LOW;
            ch_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sm_reg <= sm_next;
            band_reg <= band_next;
            ch_reg <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/tbud_datapath.sv
module tbud_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tbud_pkg::cmd_t                      cmd,
    input  logic                                cfg_we,
    input  logic [tbud_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbud_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       right_sample,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out
);

    localparam int EXT_BITS = 32 - SAMPLE_BITS;
    localparam int TAB = 1 << LOG_TABLE_BITS;
    localparam int ACC_W = 48;
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

    logic [15:0] low_cross_reg;
    logic [15:0] high_cross_reg;
    logic [16:0] depth_reg;
    logic [15:0] attack_reg;
    logic [15:0] release_reg;
    logic signed [13:0] low_makeup_reg;
    logic signed [13:0] mid_makeup_reg;
    logic signed [13:0] high_makeup_reg;

    logic signed [31:0] x_l_reg;
    logic signed [31:0] x_r_reg;
    logic signed [31:0] lp_l_reg;
    logic signed [31:0] lp_r_reg;
    logic signed [31:0] hp_l_reg;
    logic signed [31:0] hp_r_reg;
    logic [31:0] env_low_reg;
    logic [31:0] env_mid_reg;
    logic [31:0] env_high_reg;
    logic signed [63:0] prod_reg;
    logic signed [32:0] band_reg;
    logic signed [21:0] lg_reg;
    logic above_reg;
    logic [5:0] sh_reg;
    logic signed [43:0] wet_reg;
    logic signed [ACC_W-1:0] acc_l_reg;
    logic signed [ACC_W-1:0] acc_r_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    logic [15:0] log_rom [TAB];
    logic [16:0] exp_rom [TAB];

    for (genvar gi = 0; gi < TAB; gi++)
    begin : g_rom
        localparam logic [15:0] LOG_V = tbud_pkg::log_entry(LOG_TABLE_BITS, gi);
        localparam logic [16:0] EXP_V = tbud_pkg::exp_mant(LOG_TABLE_BITS, gi);
        assign log_rom[gi] = LOG_V;
        assign exp_rom[gi] = EXP_V;
    end

    logic [15:0] cross_raw;
    logic [15:0] cross_c;
    logic [16:0] depth_c;
    logic signed [31:0] s_sel;
    logic signed [31:0] x_ch;
    logic signed [31:0] lp_ch;
    logic signed [31:0] hp_ch;
    logic signed [32:0] band_val;
    logic [31:0] env_k;
    logic [32:0] mag_wide;
    logic [31:0] mag;
    logic [15:0] a_coef;
    logic [31:0] env_new;
    logic [31:0] e_val;
    logic [4:0] msb;
    logic [31:0] e_norm;
    logic [LOG_TABLE_BITS-1:0] log_idx;
    logic signed [21:0] lg_next;
    logic signed [15:0] db;
    logic signed [15:0] thr;
    logic above;
    logic signed [16:0] diff;
    logic [15:0] gq;
    logic signed [16:0] gain;
    logic signed [13:0] makeup;
    logic signed [17:0] t_val;
    logic signed [8:0] sh_wide;
    logic [5:0] sh_next;
    logic [LOG_TABLE_BITS-1:0] exp_idx;
    logic signed [31:0] s_new;
    logic signed [43:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [ACC_W-1:0] acc_sel;
    logic signed [ACC_W-1:0] acc_new;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] v;
        v = a >>> EXT_BITS;
        if (v > OUT_MAX)
        begin
            v = OUT_MAX;
        end
        else if (v < OUT_MIN)
        begin
            v = OUT_MIN;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] x_ch_sel(input logic [1:0] sel);
        return sel[0] ? x_r_reg : x_l_reg;
    endfunction

    always_comb
    begin
        cross_raw = cmd.sel[1] ? high_cross_reg : low_cross_reg;
        cross_c = (cross_raw > tbud_pkg::CROSS_MAX) ? tbud_pkg::CROSS_MAX : cross_raw;
        depth_c = (depth_reg > tbud_pkg::DEPTH_ONE) ? tbud_pkg::DEPTH_ONE : depth_reg;
        case (cmd.sel)
            tbud_pkg::SM_LP_L: s_sel = lp_l_reg;
            tbud_pkg::SM_LP_R: s_sel = lp_r_reg;
            tbud_pkg::SM_HP_L: s_sel = hp_l_reg;
            default:           s_sel = hp_r_reg;
        endcase
        x_ch = cmd.ch ? x_r_reg : x_l_reg;
        lp_ch = cmd.ch ? lp_r_reg : lp_l_reg;
        hp_ch = cmd.ch ? hp_r_reg : hp_l_reg;
        case (cmd.band)
            tbud_pkg::BAND_LOW:
            begin
                env_k = env_low_reg;
                makeup = low_makeup_reg;
                band_val = 33'(lp_ch);
            end
            tbud_pkg::BAND_MID:
            begin
                env_k = env_mid_reg;
                makeup = mid_makeup_reg;
                band_val = 33'(hp_ch) - 33'(lp_ch);
            end
            default:
            begin
                env_k = env_high_reg;
                makeup = high_makeup_reg;
                band_val = 33'(x_ch) - 33'(hp_ch);
            end
        endcase

        // envelope
        mag_wide = band_reg[32] ? 33'(-band_reg) : 33'(band_reg);
        mag = mag_wide[32] ? 32'hFFFF_FFFF : mag_wide[31:0];
        a_coef = (mag > env_k) ? attack_reg : release_reg;
        env_new = mag + prod_reg[47:16];

        // level to log2
        e_val = (env_k < tbud_pkg::ENV_FLOOR) ? tbud_pkg::ENV_FLOOR : env_k;
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (e_val[i])
            begin
                msb = 5'(i);
            end
        end
        e_norm = e_val << (5'd31 - msb);
        log_idx = e_norm[30 -: LOG_TABLE_BITS];
        lg_next = $signed({6'({1'b0, msb} - 6'd31), 16'd0}) + $signed({6'd0, log_rom[log_idx]});

        // gain computer
        db = prod_reg[39:24];
        thr = tbud_pkg::thr_db(cmd.band);
        above = (db > thr);
        diff = above ? (17'(db) - 17'(thr)) : (17'(thr) - 17'(db));
        gq = prod_reg[31:16];
        if (above_reg)
        begin
            gain = -$signed({1'b0, gq});
        end
        else
        begin
            gain = $signed({1'b0, (gq > tbud_pkg::UP_CAP) ? tbud_pkg::UP_CAP : gq});
        end
        t_val = 18'(gain) + 18'(makeup);

        // exp2 split
        sh_wide = 9'sd16 - 9'($signed(prod_reg[31:24]));
        if (sh_wide > 9'sd62)
        begin
            sh_next = 6'd62;
        end
        else if (sh_wide < 9'sd0)
        begin
            sh_next = 6'd0;
        end
        else
        begin
            sh_next = sh_wide[5:0];
        end
        exp_idx = prod_reg[23 -: LOG_TABLE_BITS];

        s_new = s_sel + prod_reg[47:16];
        acc_sel = cmd.ch ? acc_r_reg : acc_l_reg;
        acc_new = acc_sel + ACC_W'(band_reg) + prod_reg[ACC_W+15:16];

        case (cmd.op)
            tbud_pkg::OP_SM_MUL:
            begin
                mul_a = 44'(33'(x_ch_sel(cmd.sel)) - 33'(s_sel));
                mul_b = $signed({4'd0, cross_c});
            end
            tbud_pkg::OP_ENV_MUL:
            begin
                mul_a = 44'($signed({1'b0, env_k}) - $signed({1'b0, mag}));
                mul_b = $signed({4'd0, a_coef});
            end
            tbud_pkg::OP_DB_MUL:
            begin
                mul_a = 44'(lg_reg);
                mul_b = tbud_pkg::DB_PER_LOG2;
            end
            tbud_pkg::OP_GAIN_MUL:
            begin
                mul_a = 44'(diff);
                mul_b = $signed({3'd0, above ? tbud_pkg::down_slope(cmd.band)
                                             : tbud_pkg::up_slope(cmd.band)});
            end
            tbud_pkg::OP_T_MUL:
            begin
                mul_a = 44'(t_val);
                mul_b = tbud_pkg::LOG2_PER_DB;
            end
            tbud_pkg::OP_WET_MUL:
            begin
                mul_a = 44'(band_reg);
                mul_b = $signed({3'd0, exp_rom[exp_idx]});
            end
            tbud_pkg::OP_MIX_MUL:
            begin
                mul_a = wet_reg - 44'(band_reg);
                mul_b = $signed({3'd0, depth_c});
            end
            default:
            begin
                mul_a = 44'sd0;
                mul_b = 20'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cross_reg <= tbud_pkg::LOW_CROSS_RESET;
            high_cross_reg <= tbud_pkg::HIGH_CROSS_RESET;
            depth_reg <= tbud_pkg::DEPTH_RESET;
            attack_reg <= tbud_pkg::ATTACK_RESET;
            release_reg <= tbud_pkg::RELEASE_RESET;
            low_makeup_reg <= 14'sd0;
            mid_makeup_reg <= 14'sd0;
            high_makeup_reg <= 14'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbud_pkg::REG_LOW_CROSS:   low_cross_reg <= cfg_data[15:0];
                tbud_pkg::REG_HIGH_CROSS:  high_cross_reg <= cfg_data[15:0];
                tbud_pkg::REG_DEPTH:       depth_reg <= cfg_data;
                tbud_pkg::REG_ATTACK:      attack_reg <= cfg_data[15:0];
                tbud_pkg::REG_RELEASE:     release_reg <= cfg_data[15:0];
                tbud_pkg::REG_LOW_MAKEUP:  low_makeup_reg <= cfg_data[13:0];
                tbud_pkg::REG_MID_MAKEUP:  mid_makeup_reg <= cfg_data[13:0];
                tbud_pkg::REG_HIGH_MAKEUP: high_makeup_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // filter and envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_l_reg <= 32'sd0;
            lp_r_reg <= 32'sd0;
            hp_l_reg <= 32'sd0;
            hp_r_reg <= 32'sd0;
            env_low_reg <= 32'd0;
            env_mid_reg <= 32'd0;
            env_high_reg <= 32'd0;
        end
        else
        begin
            if (cmd.op == tbud_pkg::OP_SM_ADD)
            begin
                case (cmd.sel)
                    tbud_pkg::SM_LP_L: lp_l_reg <= s_new;
                    tbud_pkg::SM_LP_R: lp_r_reg <= s_new;
                    tbud_pkg::SM_HP_L: hp_l_reg <= s_new;
                    default:           hp_r_reg <= s_new;
                endcase
            end
            if (cmd.op == tbud_pkg::OP_ENV_UPD)
            begin
                case (cmd.band)
                    tbud_pkg::BAND_LOW: env_low_reg <= env_new;
                    tbud_pkg::BAND_MID: env_mid_reg <= env_new;
                    default:            env_high_reg <= env_new;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tbud_pkg::OP_LOAD:
            begin
                x_l_reg <= 32'(left_sample) <<< EXT_BITS;
                x_r_reg <= 32'(right_sample) <<< EXT_BITS;
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end
            tbud_pkg::OP_SM_MUL:   prod_reg <= mul_p;
            tbud_pkg::OP_BAND:     band_reg <= band_val;
            tbud_pkg::OP_ENV_MUL:  prod_reg <= mul_p;
            tbud_pkg::OP_LOG:      lg_reg <= lg_next;
            tbud_pkg::OP_DB_MUL:   prod_reg <= mul_p;
            tbud_pkg::OP_GAIN_MUL:
            begin
                prod_reg <= mul_p;
                above_reg <= above;
            end
            tbud_pkg::OP_T_MUL:    prod_reg <= mul_p;
            tbud_pkg::OP_WET_MUL:
            begin
                prod_reg <= mul_p;
                sh_reg <= sh_next;
            end
            tbud_pkg::OP_WET_SH:   wet_reg <= 44'(prod_reg >>> sh_reg);
            tbud_pkg::OP_MIX_MUL:  prod_reg <= mul_p;
            tbud_pkg::OP_MIX_ACC:
            begin
                if (cmd.ch)
                begin
                    acc_r_reg <= acc_new;
                end
                else
                begin
                    acc_l_reg <= acc_new;
                end
            end
            tbud_pkg::OP_OUT:
            begin
                left_out_reg <= sat_out(acc_l_reg);
                right_out_reg <= sat_out(acc_r_reg);
            end
            default: ;
        endcase
    end

    assign left_out = left_out_reg;
    assign right_out = right_out_reg;

endmodule

>>> rtl/core/three_band_upward_downward_compressor.sv
// channel     dir  handshake      payload
// sample_in   in   valid/ready    left_sample, right_sample (signed SAMPLE_BITS)
// sample_out  out  valid/ready    left_out, right_out (signed SAMPLE_BITS, saturated)
// cfg         in   cfg_we         cfg_index (3 bits), cfg_data (17 bits), no read-back
//
// one request at a time through one shared multiplier: crossover filtering
// first, then six band and channel passes of envelope, log, gain, exp2 and mix
// steps, then the output register load, which waits while a result is not taken.
// the output register lets the next request in while a result waits.
// rst_n resets the control state, filter and envelope state, and config registers.
module three_band_upward_downward_compressor #(
    parameter int SAMPLE_BITS = 24,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tbud_in_if.sink                           sample_in,
    tbud_out_if.source                        sample_out,
    input  logic                              cfg_we,
    input  logic [tbud_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbud_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tbud_pkg::cmd_t cmd;

    tbud_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (sample_out.valid),
        .out_ready (sample_out.ready),
        .cmd       (cmd)
    );

    tbud_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (sample_in.left_sample),
        .right_sample (sample_in.right_sample),
        .left_out     (sample_out.left_out),
        .right_out    (sample_out.right_out)
    );

endmodule

>>> dv/three_band_upward_downward_compressor_test.sv
`timescale 1ns / 1ps

module three_band_upward_downward_compressor_test;

    class compressor_scoreboard;
        logic [16:0]              regs [8];
        longint                   lp_l, lp_r, hs_l, hs_r;
        longint unsigned          env [3];
        longint unsigned          log_tab [256];
        longint unsigned          exp_tab [256];
        logic signed [23:0]       exp_left [$];
        logic signed [23:0]       exp_right [$];
        int                       errors;
        int                       seen;

        function longint unsigned root64(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void init();
            longint unsigned roots [9];
            longint unsigned v;
            longint unsigned y;
            longint unsigned acc;
            longint unsigned r;
            v = 64'd2 << 30;
            for (int j = 1; j <= 8; j++)
            begin
                v = root64(v << 30);
                roots[j] = v;
            end
            for (int i = 0; i < 256; i++)
            begin
                y = longint'(256 + i) << 22;
                r = 0;
                acc = 64'd1 << 30;
                for (int b = 15; b >= 0; b--)
                begin
                    y = (y * y) >> 30;
                    if (y >= (64'd2 << 30))
                    begin
                        y = y >> 1;
                        r = r | (64'd1 << b);
                    end
                end
                log_tab[i] = r;
                for (int j = 1; j <= 8; j++)
                    if (((i >> (8 - j)) & 1) != 0)
                        acc = (acc * roots[j]) >> 30;
                exp_tab[i] = acc;
            end
            regs[tbud_pkg::REG_LOW_CROSS] = 17'(tbud_pkg::LOW_CROSS_RESET);
            regs[tbud_pkg::REG_HIGH_CROSS] = 17'(tbud_pkg::HIGH_CROSS_RESET);
            regs[tbud_pkg::REG_DEPTH] = tbud_pkg::DEPTH_RESET;
            regs[tbud_pkg::REG_ATTACK] = 17'(tbud_pkg::ATTACK_RESET);
            regs[tbud_pkg::REG_RELEASE] = 17'(tbud_pkg::RELEASE_RESET);
            regs[tbud_pkg::REG_LOW_MAKEUP] = 17'd0;
            regs[tbud_pkg::REG_MID_MAKEUP] = 17'd0;
            regs[tbud_pkg::REG_HIGH_MAKEUP] = 17'd0;
            lp_l = 0; lp_r = 0; hs_l = 0; hs_r = 0;
            for (int k = 0; k < 3; k++)
                env[k] = 0;
            errors = 0;
            seen = 0;
        endfunction

        function void set_reg(int idx, logic [16:0] data);
            if (idx == tbud_pkg::REG_DEPTH)
                regs[idx] = data;
            else if (idx >= tbud_pkg::REG_LOW_MAKEUP)
                regs[idx] = {3'd0, data[13:0]};
            else
                regs[idx] = {1'b0, data[15:0]};
        endfunction

        function longint smooth_step(ref longint s, input longint x, input longint c);
            longint v;
            v = s + ((c * (x - s)) >>> 16);
            s = longint'(int'(v));
            return s;
        endfunction

        function longint band_gain(int k, longint band);
            longint unsigned mag;
            longint unsigned a;
            longint unsigned e;
            int msb;
            int idx;
            longint lg, db, gain, t, y, n, frac, sh, wet, depth, thr;
            mag = band < 0 ? -band : band;
            if (mag > 64'hFFFF_FFFF)
                mag = 64'hFFFF_FFFF;
            a = (mag > env[k]) ? regs[tbud_pkg::REG_ATTACK] : regs[tbud_pkg::REG_RELEASE];
            env[k] = (a * env[k] + (65536 - a) * mag) >> 16;
            e = env[k] < tbud_pkg::ENV_FLOOR ? tbud_pkg::ENV_FLOOR : env[k];
            msb = 31;
            while (e[msb] == 1'b0)
                msb--;
            idx = (msb >= 8) ? int'((e >> (msb - 8)) & 255) : int'((e << (8 - msb)) & 255);
            lg = longint'(msb - 31) * 65536 + longint'(log_tab[idx]);
            db = (lg * 394566) >>> 24;
            thr = thr_db_of(k);
            if (db > thr)
                gain = -(((db - thr) * down_of(k)) >>> 16);
            else
            begin
                gain = ((thr - db) * up_of(k)) >>> 16;
                if (gain > 4608)
                    gain = 4608;
            end
            t = gain + longint'($signed(regs[tbud_pkg::REG_LOW_MAKEUP + k][13:0]));
            y = (t * 10885) >>> 8;
            n = y >>> 16;
            frac = y - n * 65536;
            idx = int'((frac >> 8) & 255);
            sh = 16 - n;
            if (sh > 62)
                sh = 62;
            if (sh < 0)
                sh = 0;
            wet = (band * longint'(exp_tab[idx] >> 14)) >>> sh;
            depth = regs[tbud_pkg::REG_DEPTH] > 65536 ? 65536
                                                      : longint'(regs[tbud_pkg::REG_DEPTH]);
            return (band * (65536 - depth) + wet * depth) >>> 16;
        endfunction

        function longint thr_db_of(int k);
            return k == 0 ? -5120 : (k == 1 ? -4608 : -3840);
        endfunction

        function longint down_of(int k);
            return k == 0 ? 54613 : (k == 1 ? 57344 : 58982);
        endfunction

        function longint up_of(int k);
            return k == 0 ? 46811 : (k == 1 ? 49152 : 50972);
        endfunction

        function logic signed [23:0] to_sample(longint sum);
            longint v;
            v = sum >>> 8;
            if (v > 8388607)
                v = 8388607;
            if (v < -8388608)
                v = -8388608;
            return 24'(v);
        endfunction

        function void note_request(logic signed [23:0] left, logic signed [23:0] right);
            longint cl, ch, xl, xr, lpl, lpr, hpl, hpr, sl, sr;
            cl = regs[tbud_pkg::REG_LOW_CROSS] > 64880 ? 64880
                                                       : longint'(regs[tbud_pkg::REG_LOW_CROSS]);
            ch = regs[tbud_pkg::REG_HIGH_CROSS] > 64880 ? 64880
                                                        : longint'(regs[tbud_pkg::REG_HIGH_CROSS]);
            xl = longint'(left) * 256;
            xr = longint'(right) * 256;
            lpl = smooth_step(lp_l, xl, cl);
            lpr = smooth_step(lp_r, xr, cl);
            hpl = smooth_step(hs_l, xl, ch);
            hpr = smooth_step(hs_r, xr, ch);
            sl = band_gain(0, lpl);
            sr = band_gain(0, lpr);
            sl += band_gain(1, hpl - lpl);
            sr += band_gain(1, hpr - lpr);
            sl += band_gain(2, xl - hpl);
            sr += band_gain(2, xr - hpr);
            exp_left.push_back(to_sample(sl));
            exp_right.push_back(to_sample(sr));
        endfunction

        function void check_result(logic signed [23:0] left, logic signed [23:0] right);
            logic signed [23:0] el;
            logic signed [23:0] er;
            seen++;
            if (exp_left.size() == 0)
            begin
                $display("%0t: unexpected result left %0d right %0d", $time, left, right);
                errors++;
                return;
            end
            el = exp_left.pop_front();
            er = exp_right.pop_front();
            if (left !== el)
            begin
                $display("%0t: left_out expected %0d actual %0d", $time, el, left);
                errors++;
            end
            if (right !== er)
            begin
                $display("%0t: right_out expected %0d actual %0d", $time, er, right);
                errors++;
            end
        endfunction

        function int pending();
            return exp_left.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tbud_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tbud_pkg::CFG_DATA_W-1:0] cfg_data;
    int src_idle_pct;
    int snk_idle_pct;
    int sent;
    compressor_scoreboard sb;

    tbud_in_if #(.SAMPLE_BITS(24)) in_if ();
    tbud_out_if #(.SAMPLE_BITS(24)) out_if ();

    three_band_upward_downward_compressor u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_in(in_if),
        .sample_out(out_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(negedge clk)
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.left_out, out_if.right_out);

    task automatic write_reg(logic [tbud_pkg::CFG_IDX_W-1:0] idx,
                             logic [tbud_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(logic signed [23:0] left, logic signed [23:0] right);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.left_sample <= left;
        in_if.right_sample <= right;
        do
            @(posedge clk);
        while (!(in_if.valid && in_if.ready));
        sb.note_request(left, right);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        logic signed [23:0] s;
        s = 24'($urandom);
        case ($urandom_range(9))
            0: s = 24'sh7FFFFF;
            1: s = -24'sh800000;
            2, 3: s = s;
            default: s = s >>> $urandom_range(23, 2);
        endcase
        return s;
    endfunction

    task automatic set_all(logic [16:0] lc, logic [16:0] hc, logic [16:0] dp, logic [16:0] at,
                           logic [16:0] rl, logic [16:0] m0, logic [16:0] m1, logic [16:0] m2);
        write_reg(tbud_pkg::REG_LOW_CROSS, lc);
        write_reg(tbud_pkg::REG_HIGH_CROSS, hc);
        write_reg(tbud_pkg::REG_DEPTH, dp);
        write_reg(tbud_pkg::REG_ATTACK, at);
        write_reg(tbud_pkg::REG_RELEASE, rl);
        write_reg(tbud_pkg::REG_LOW_MAKEUP, m0);
        write_reg(tbud_pkg::REG_MID_MAKEUP, m1);
        write_reg(tbud_pkg::REG_HIGH_MAKEUP, m2);
    endtask

    initial
    begin
        logic signed [23:0] a;
        logic signed [23:0] b;
        int n;
        sb = new();
        sb.init();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.left_sample = '0;
        in_if.right_sample = '0;
        out_if.ready = 1'b0;
        src_idle_pct = 34;
        snk_idle_pct = 48;
        sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, silence, steps and alternation at reset settings
        send_request(24'sh7FFFFF, -24'sh800000);
        send_request(-24'sh800000, 24'sh7FFFFF);
        send_request(24'sd0, 24'sd0);
        for (int i = 0; i < 6; i++)
            send_request(24'sh7FFFFF, 24'sh7FFFFF);
        for (int i = 0; i < 6; i++)
            send_request(i[0] ? 24'sh7FFFFF : -24'sh800000, i[0] ? -24'sh800000 : 24'sh7FFFFF);
        for (int i = 0; i < 6; i++)
            send_request(24'sd1, -24'sd1);
        send_request(24'sh555555, 24'shAAAAAA);
        send_request(24'shAAAAAA, 24'sh555555);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_all(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'h1E800, 17'h1E800, 17'h1E800);
                1: set_all(17'h0FFFF, 17'h0FFFF, 17'h1FFFF, 17'h0FFFF, 17'h0FFFF,
                           17'd6144, 17'd6144, 17'd6144);
                2: set_all(17'd64880, 17'd64880, 17'd65536, 17'd1, 17'd65535,
                           17'h1FFF, 17'h2000, 17'd0);
                5: set_all(17'd1928, 17'd34242, 17'd65536, 17'd64170, 17'd65372,
                           17'($urandom_range(16383)), 17'($urandom_range(16383)),
                           17'($urandom_range(16383)));
                default: set_all(17'($urandom_range(65535)), 17'($urandom_range(65535)),
                                 17'($urandom_range(65536)), 17'($urandom_range(65535)),
                                 17'($urandom_range(65535)), 17'($urandom_range(16383)),
                                 17'($urandom_range(16383)), 17'($urandom_range(16383)));
            endcase
            src_idle_pct = p < 2 ? 34 : (p < 4 ? 48 : 0);
            snk_idle_pct = p < 2 ? 48 : (p < 4 ? 34 : 0);
            n = 0;
            while (n < 205)
            begin
                // mostly bursts of a held level with noise, the rest fully random
                a = rand_sample();
                b = rand_sample();
                for (int j = $urandom_range(12, 1); j > 0 && n < 205; j--)
                begin
                    if ($urandom_range(3) == 0)
                        send_request(rand_sample(), rand_sample());
                    else
                        send_request(a ^ 24'($urandom_range(255)), b ^ 24'($urandom_range(255)));
                    n++;
                end
                if (p == 3 && n > 100 && n < 110)
                    drain();
            end
            drain();
        end

        $display("ran %0d requests through reset, extreme and random settings", sent);
        $display("with sender and receiver stalls in both orders; %0d results checked", sb.seen);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
